// File: sv/tsii_pkg.sv
// Shared types and constants of the two-set insert and intersect block.
package tsii_pkg;

    // Capacity of each set and the number of value bits that are kept.
    localparam int SET_SIZE   = 8;
    localparam int VALUE_BITS = 16;

    // Width of the value field on the ports.
    localparam int VALUE_W = 16;

    // A fill count must hold SET_SIZE itself; a slot index only the slots.
    localparam int CNT_W = $clog2(SET_SIZE + 1);
    localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

    // Mask that drops value bits above VALUE_BITS.
    localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        FN_INS_A  = 2'd0,
        FN_INS_B  = 2'd1,
        FN_ISECT  = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_COMMON    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_INS,
        SQ_CLR,
        SQ_WALK,
        SQ_WEND
    } state_t;

endpackage

// File: sv/two_set_insert_and_intersect.sv
// Top level of the two-set insert and intersect block: sequencer, set storage and compare unit.
//
// Usage:
// Commands arrive as beats on the slave stream: tuser[1:0] holds the command
// (insert into A, insert into B, intersect, clear both) and tdata[15:0] the
// value to insert. Results leave as beats on the master stream: tuser[2:0]
// holds the status, tdata[15:0] the value and tlast marks the final result
// beat of a command.
// One command is handled at a time; s_axis_tready is high only while the
// sequencer is idle. An insert or a clear moves from idle to its own state,
// which loads the result into the output register once that register is
// free and then returns to idle. An intersect checks one slot of A per cycle,
// unless a held match waits for a busy output register, with the single
// compare unit, which tests a key against every filled slot of the selected
// set at once. A match is held back by one step so that the last one can
// carry tlast.
// The output register lets the next command be accepted while the final
// result still waits. When the receiver stalls, the sequencer waits at the
// next result it has to hand over and the register holds its beat.
// Reset empties both sets and the output register; no clearing pass is run.
module two_set_insert_and_intersect
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] item_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] result_value
    output logic [2:0]  m_axis_tuser,  // [2:0] status
    output logic       m_axis_tlast
);
    import tsii_pkg::*;

    // Sequencer and command registers.
    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [VALUE_W-1:0]   pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;

    // Set storage.
    logic [VALUE_W-1:0]   a_mem_reg [SET_SIZE];
    logic [VALUE_W-1:0]   b_mem_reg [SET_SIZE];
    logic [CNT_W-1:0]     a_count_reg, a_count_next;
    logic [CNT_W-1:0]     b_count_reg, b_count_next;
    logic                 a_wr_en, b_wr_en;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free;
    logic                 out_load;

    // Shared compare unit.
    logic                 cmp_use_b;
    logic [VALUE_W-1:0]   cmp_key;
    logic [CNT_W-1:0]     cmp_count;
    logic                 cmp_hit;

    // The compare unit tests one key against all filled slots of one set.
    always_comb
    begin
        cmp_use_b = (state_reg == SQ_WALK) || (func_reg == FN_INS_B);
        cmp_key   = (state_reg == SQ_WALK) ? a_mem_reg[idx_reg[IDX_W-1:0]] : key_reg;
        cmp_count = cmp_use_b ? b_count_reg : a_count_reg;
        cmp_hit   = 1'b0;
        for (int j = 0; j < SET_SIZE; j++)
        begin
            if (CNT_W'(j) < cmp_count)
            begin
                if ((cmp_use_b ? b_mem_reg[j] : a_mem_reg[j]) == cmp_key)
                begin
                    cmp_hit = 1'b1;
                end
            end
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == SQ_IDLE);

    // Next state, set updates and result beats.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        a_count_next    = a_count_reg;
        b_count_next    = b_count_reg;
        a_wr_en         = 1'b0;
        b_wr_en         = 1'b0;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;

        case (state_reg)
            SQ_IDLE:
            begin
                // Take a command beat and decide which sequence runs.
                if (s_axis_tvalid)
                begin
                    func_next       = func_t'(s_axis_tuser);
                    key_next        = s_axis_tdata & VALUE_MASK;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    case (func_t'(s_axis_tuser))
                        FN_INS_A, FN_INS_B: state_next = SQ_INS;
                        FN_ISECT:           state_next = SQ_WALK;
                        FN_CLEAR:           state_next = SQ_CLR;
                        default:            state_next = SQ_IDLE;
                    endcase
                end
            end

            SQ_INS:
            begin
                // Duplicate check comes before the full check.
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (cmp_hit)
                    begin
                        out_status_next = ST_DUPLICATE;
                        out_value_next  = '0;
                    end
                    else if (cmp_count >= CNT_W'(SET_SIZE))
                    begin
                        out_status_next = ST_FULL;
                        out_value_next  = '0;
                    end
                    else
                    begin
                        out_status_next = ST_INSERTED;
                        out_value_next  = key_reg;
                        if (func_reg == FN_INS_B)
                        begin
                            b_wr_en      = 1'b1;
                            b_count_next = b_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            a_wr_en      = 1'b1;
                            a_count_next = a_count_reg + CNT_W'(1);
                        end
                    end
                    state_next = SQ_IDLE;
                end
            end

            SQ_CLR:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_CLEARED;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    a_count_next    = '0;
                    b_count_next    = '0;
                    state_next      = SQ_IDLE;
                end
            end

            SQ_WALK:
            begin
                // One slot of A per cycle unless output stalls; a match waits for the next.
                if (idx_reg >= a_count_reg)
                begin
                    state_next = SQ_WEND;
                end
                else if (cmp_hit && pend_valid_reg && !out_free)
                begin
                    state_next = SQ_WALK;
                end
                else
                begin
                    if (cmp_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_status_next = ST_COMMON;
                            out_value_next  = pend_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_next       = cmp_key;
                        pend_valid_next = 1'b1;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            SQ_WEND:
            begin
                // Final beat: the held match, or the empty status.
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = pend_valid_reg ? ST_COMMON : ST_EMPTY;
                    out_value_next  = pend_valid_reg ? pend_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = SQ_IDLE;
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            a_count_reg    <= '0;
            b_count_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            a_count_reg    <= a_count_next;
            b_count_reg    <= b_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        pend_reg       <= pend_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    // Set storage writes at the current fill count.
    always_ff @(posedge clk)
    begin
        if (a_wr_en)
        begin
            a_mem_reg[a_count_reg[IDX_W-1:0]] <= key_reg;
        end
        if (b_wr_en)
        begin
            b_mem_reg[b_count_reg[IDX_W-1:0]] <= key_reg;
        end
    end

    // Output ports.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // A set never holds more members than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_count_reg <= CNT_W'(SET_SIZE)) && (b_count_reg <= CNT_W'(SET_SIZE)))
        else $error("set fill count beyond capacity");

    // Only a common member can be followed by more result beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_last_next) |-> (out_status_next == ST_COMMON))
        else $error("non-final result beat with a status other than common member");

    // The walk index never passes the fill count of A.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_WALK) |-> (idx_reg <= a_count_reg))
        else $error("intersect walk beyond the filled slots of A");

    // A new result beat is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> !$changed(out_value_reg) || !out_valid_reg)
        else $error("pending result beat overwritten");

endmodule
